/* design/assert_macros.svh */
// assertion macros used by the rtl of the region statistics block
// depends on nothing; each macro expands to one concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

/* design/rls_pkg.sv */
// shared types and constants of the region label statistics block
// depends on nothing
package rls_pkg;

   // field and accumulator widths
   localparam int LABEL_IN_W = 10;
   localparam int XY_IN_W    = 12;
   localparam int CH_W       = 8;
   localparam int CHAN_N     = 6;
   localparam int CNT_W      = 24;
   localparam int SUM_W      = 32;
   localparam int SQ_W       = 40;
   localparam int HCNT_W     = 24;
   localparam int VALUE_W    = 40;
   localparam int WORD_W     = 6;
   localparam int CFG_W      = 11;
   localparam int BASE_WORDS = 14;

   // stream packing
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 48;

   // divider and square root sizes
   localparam int DIV_Q_W = 40;
   localparam int DIV_D_W = 48;
   localparam int DIV_N_W = DIV_Q_W + DIV_D_W;
   localparam int SQRT_W  = 32;

   // parameter defaults
   localparam int MAX_LABELS_DEF = 1024;
   localparam int COORD_BITS_DEF = 12;
   localparam int HIST_BINS_DEF  = 8;

   localparam logic [CNT_W-1:0] COUNT_MAX       = 24'hFF_FFFF;
   localparam logic [CFG_W-1:0] LABEL_COUNT_RST = 11'd1024;

   // register indexes
   localparam logic [0:0] REG_LABEL_COUNT = 1'b0;
   localparam logic [0:0] REG_LITE_MODE   = 1'b1;

   // request kinds
   localparam logic [0:0] OP_PIXEL   = 1'b0;
   localparam logic [0:0] OP_READOUT = 1'b1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_WORD,
      S_MUL1,
      S_MUL2,
      S_ADD,
      S_SUB,
      S_DIV,
      S_SQRT,
      S_EMIT
   } seq_state_type;

endpackage

/* design/rls_ram.sv */
// generic single-clock ram with one write port and one registered read port
// depends on nothing
module rls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read, read returns old data on a collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/region_label_statistics_unit.sv */
// per-label region statistics: pixel requests update one label a cycle while no readout runs, a readout emits its words
// pixel requests: one per cycle while idle, read at acceptance, written back in the next cycle (forwarded)
// readout: a mean word runs the 40-step divider, a std word the divider plus the 16-step root,
// a histogram word neither; no request is taken meanwhile
// reset: a clearing pass writes zeros to every entry of both label memories before requests
// depends on rls_pkg, rls_ram and assert_macros.svh
`include "assert_macros.svh"

module region_label_statistics_unit import rls_pkg::*; #(
   parameter int MAX_LABELS = MAX_LABELS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int HIST_BINS  = HIST_BINS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // label_index, x_pos, y_pos, red, green, blue, lightness, chroma_a, chroma_b, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // word_index, feature_value, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // empty_label
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [0:0]            csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   localparam int ADDR_W     = $clog2(MAX_LABELS);
   localparam int XW         = (COORD_BITS < XY_IN_W) ? COORD_BITS : XY_IN_W;
   localparam int XY_SUM_W   = XW + CNT_W;
   localparam int OPS_W      = (XY_SUM_W > SUM_W) ? XY_SUM_W : SUM_W;
   localparam int OFF_X      = CNT_W;
   localparam int OFF_Y      = OFF_X + XY_SUM_W;
   localparam int OFF_S      = OFF_Y + XY_SUM_W;
   localparam int OFF_Q      = OFF_S + CHAN_N * SUM_W;
   localparam int STATS_W    = OFF_Q + CHAN_N * SQ_W;
   localparam int HIST_N     = CHAN_N * HIST_BINS;
   localparam int HIST_W     = HIST_N * HCNT_W;
   localparam int HB_W       = $clog2(HIST_BINS);
   localparam int TOTAL_FULL = BASE_WORDS + HIST_N;
   localparam int K_W        = $clog2(TOTAL_FULL + 1);
   localparam int RSP_PAD    = RSP_DATA_W - WORD_W - VALUE_W;
   localparam int MUL_W      = CNT_W + SQ_W / 2;
   localparam int SQ_LO_W    = SQ_W / 2;

   // configuration
   logic [CFG_W-1:0] label_count_ff;
   logic             lite_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         label_count_ff <= LABEL_COUNT_RST;
         lite_ff        <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_LABEL_COUNT: label_count_ff <= csr_wdata;
            REG_LITE_MODE:   lite_ff        <= csr_wdata[0];
            default:         ;
         endcase
      end
   end

   seq_state_type state_ff, state_in;

   // accepted request, registered alongside the memory read data
   logic                  p1_valid_ff;
   logic [0:0]            p1_op_ff;
   logic [LABEL_IN_W-1:0] p1_label_ff;
   logic [XW-1:0]         p1_x_ff, p1_y_ff;
   logic [CH_W-1:0]       p1_ch_ff [CHAN_N];
   logic                  req_fire;

   assign req_tready = (state_ff == S_IDLE) && !(p1_valid_ff && p1_op_ff == OP_READOUT);
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         p1_op_ff    <= req_tuser;
         p1_label_ff <= req_tdata[LABEL_IN_W-1:0];
         p1_x_ff     <= req_tdata[10 +: XW];
         p1_y_ff     <= req_tdata[22 +: XW];
         for (int c = 0; c < CHAN_N; c++) begin
            p1_ch_ff[c] <= req_tdata[34 + c * CH_W +: CH_W];
         end
      end
   end

   // label memories
   logic [ADDR_W-1:0]  rd_addr, wr_addr, p1_addr;
   logic [ADDR_W-1:0]  clr_ff;
   logic [STATS_W-1:0] stats_rd, stats_wdata, stats_cur, stats_upd;
   logic [HIST_W-1:0]  hist_rd, hist_wdata, hist_cur, hist_upd;
   logic               stats_we, hist_we;

   assign rd_addr = ADDR_W'(req_tdata[LABEL_IN_W-1:0]);
   assign p1_addr = ADDR_W'(p1_label_ff);

   rls_ram #(.WIDTH(STATS_W), .DEPTH(MAX_LABELS)) u_stats_ram (
      .clock   (clock),
      .wr_en   (stats_we),
      .wr_addr (wr_addr),
      .wr_data (stats_wdata),
      .rd_addr (rd_addr),
      .rd_data (stats_rd)
   );

   rls_ram #(.WIDTH(HIST_W), .DEPTH(MAX_LABELS)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (wr_addr),
      .wr_data (hist_wdata),
      .rd_addr (rd_addr),
      .rd_data (hist_rd)
   );

   // forwarding of the previous cycle's write
   logic               fwd_s_ff, fwd_h_ff;
   logic [ADDR_W-1:0]  fwd_addr_ff;
   logic [STATS_W-1:0] fwd_stats_ff;
   logic [HIST_W-1:0]  fwd_hist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_s_ff <= 1'b0;
         fwd_h_ff <= 1'b0;
      end else begin
         fwd_s_ff <= stats_we;
         fwd_h_ff <= hist_we;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff  <= wr_addr;
      fwd_stats_ff <= stats_wdata;
      fwd_hist_ff  <= hist_wdata;
   end

   assign stats_cur = (fwd_s_ff && fwd_addr_ff == p1_addr) ? fwd_stats_ff : stats_rd;
   assign hist_cur  = (fwd_h_ff && fwd_addr_ff == p1_addr) ? fwd_hist_ff : hist_rd;

   // pixel update of one label
   logic                 in_range, cnt_full, start_read;
   logic [CNT_W-1:0]     cur_cnt;
   logic [HB_W-1:0]      bin;

   assign in_range   = ({1'b0, p1_label_ff} < label_count_ff)
                    && ({22'b0, p1_label_ff} < 32'(MAX_LABELS));
   assign cur_cnt    = stats_cur[0 +: CNT_W];
   assign cnt_full   = (cur_cnt == COUNT_MAX);
   assign start_read = (state_ff == S_IDLE) && p1_valid_ff && (p1_op_ff == OP_READOUT)
                    && in_range;

   always_comb begin
      stats_upd = stats_cur;
      hist_upd  = hist_cur;
      bin       = '0;
      stats_upd[0 +: CNT_W]        = cur_cnt + CNT_W'(1);
      stats_upd[OFF_X +: XY_SUM_W] = stats_cur[OFF_X +: XY_SUM_W] + XY_SUM_W'(p1_x_ff);
      stats_upd[OFF_Y +: XY_SUM_W] = stats_cur[OFF_Y +: XY_SUM_W] + XY_SUM_W'(p1_y_ff);
      for (int c = 0; c < CHAN_N; c++) begin
         stats_upd[OFF_S + c * SUM_W +: SUM_W] =
            stats_cur[OFF_S + c * SUM_W +: SUM_W] + SUM_W'(p1_ch_ff[c]);
         stats_upd[OFF_Q + c * SQ_W +: SQ_W] =
            stats_cur[OFF_Q + c * SQ_W +: SQ_W]
            + SQ_W'(16'(p1_ch_ff[c]) * 16'(p1_ch_ff[c]));
         bin = HB_W'((16'(p1_ch_ff[c]) * 16'(HIST_BINS)) >> 8);
         for (int h = 0; h < HIST_BINS; h++) begin
            if (HB_W'(h) == bin) begin
               hist_upd[(c * HIST_BINS + h) * HCNT_W +: HCNT_W] =
                  hist_cur[(c * HIST_BINS + h) * HCNT_W +: HCNT_W] + HCNT_W'(1);
            end
         end
      end
   end

   // write port: clearing pass, readout clear or pixel update
   always_comb begin
      logic p1_live;
      p1_live     = p1_valid_ff && in_range && (state_ff == S_IDLE);
      wr_addr     = p1_addr;
      stats_we    = 1'b0;
      hist_we     = 1'b0;
      stats_wdata = stats_upd;
      hist_wdata  = hist_upd;
      if (state_ff == S_CLEAR) begin
         wr_addr     = clr_ff;
         stats_we    = 1'b1;
         hist_we     = 1'b1;
         stats_wdata = '0;
         hist_wdata  = '0;
      end else if (p1_live && p1_op_ff == OP_READOUT) begin
         stats_we    = 1'b1;
         hist_we     = 1'b1;
         stats_wdata = '0;
         hist_wdata  = '0;
      end else if (p1_live && !cnt_full) begin
         stats_we = 1'b1;
         hist_we  = !lite_ff;
      end
   end

   // readout snapshot and sequencer datapath
   logic [CNT_W-1:0]    snap_cnt_ff;
   logic [XY_SUM_W-1:0] snap_x_ff, snap_y_ff;
   logic [SUM_W-1:0]    snap_sum_ff [CHAN_N];
   logic [SQ_W-1:0]     snap_sq_ff [CHAN_N];
   logic [HIST_W-1:0]   hist_sh_ff;
   logic                empty_ff;
   logic [K_W-1:0]      k_ff, total_ff;
   logic [SUM_W-1:0]    std_sum_ff;
   logic [SQ_W-1:0]     std_sq_ff;
   logic [MUL_W-1:0]    pa_ff, ph_ff;
   logic [63:0]         pb_ff, a_ff;
   logic [DIV_D_W-1:0]  pn_ff, dvs_ff;
   logic [DIV_D_W:0]    rem_ff, rem_in, r2;
   logic [DIV_Q_W-1:0]  nlo_ff, q_next;
   logic                div_std_ff, div_ge;
   logic [SQRT_W-1:0]   sv_ff, sr_ff, sb_ff, sv_in, sr_in;
   logic [SQRT_W:0]     trial;
   logic                sq_ge;
   logic [5:0]          it_ff;
   logic [VALUE_W-1:0]  val_ff;
   logic [64:0]         diff;

   // word classification
   logic [K_W-1:0]   t;
   logic [2:0]       ci;
   logic             is_xy, is_hist, is_std, last_k, out_free;
   logic [OPS_W-1:0] sel_sum;
   logic [DIV_N_W-1:0] mean_num, var_num;

   always_comb begin
      t       = k_ff - K_W'(2);
      ci      = 3'(t[3:2]) + (t[1] ? 3'd3 : 3'd0);
      is_xy   = (k_ff < K_W'(2));
      is_hist = (k_ff >= K_W'(BASE_WORDS));
      is_std  = !is_xy && !is_hist && t[0];
      if (is_xy) begin
         sel_sum = k_ff[0] ? OPS_W'(snap_y_ff) : OPS_W'(snap_x_ff);
      end else begin
         sel_sum = OPS_W'(snap_sum_ff[ci]);
      end
      mean_num = (DIV_N_W'(sel_sum) << 8) + DIV_N_W'(snap_cnt_ff >> 1);
      last_k   = (k_ff == total_ff - K_W'(1));
      out_free = !rsp_tvalid || rsp_tready;
   end

   // subtract, divider step and root step
   always_comb begin
      diff    = {1'b0, a_ff} - {1'b0, pb_ff};
      var_num = DIV_N_W'(diff[63:0]) << 16;
      r2      = {rem_ff[DIV_D_W-1:0], nlo_ff[DIV_Q_W-1]};
      div_ge  = (r2 >= {1'b0, dvs_ff});
      rem_in  = div_ge ? (r2 - {1'b0, dvs_ff}) : r2;
      q_next  = {nlo_ff[DIV_Q_W-2:0], div_ge};
      trial   = {1'b0, sr_ff} + {1'b0, sb_ff};
      sq_ge   = ({1'b0, sv_ff} >= trial);
      sv_in   = sq_ge ? (sv_ff - trial[SQRT_W-1:0]) : sv_ff;
      sr_in   = sq_ge ? ((sr_ff >> 1) + sb_ff) : (sr_ff >> 1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == ADDR_W'(MAX_LABELS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start_read) state_in = S_WORD;
         end
         S_WORD: begin
            if (empty_ff || is_hist) state_in = S_EMIT;
            else if (is_std)         state_in = S_MUL1;
            else                     state_in = S_DIV;
         end
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_ADD;
         S_ADD:  state_in = S_SUB;
         S_SUB: begin
            if (diff[64] || diff[63:0] == 64'd0) state_in = S_EMIT;
            else                                 state_in = S_DIV;
         end
         S_DIV: begin
            if (it_ff == 6'd0) state_in = div_std_ff ? S_SQRT : S_EMIT;
         end
         S_SQRT: begin
            if (it_ff == 6'd0) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) state_in = last_k ? S_IDLE : S_WORD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + ADDR_W'(1);
      end
   end

   // sequencer datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (start_read) begin
               snap_cnt_ff <= cur_cnt;
               snap_x_ff   <= stats_cur[OFF_X +: XY_SUM_W];
               snap_y_ff   <= stats_cur[OFF_Y +: XY_SUM_W];
               for (int c = 0; c < CHAN_N; c++) begin
                  snap_sum_ff[c] <= stats_cur[OFF_S + c * SUM_W +: SUM_W];
                  snap_sq_ff[c]  <= stats_cur[OFF_Q + c * SQ_W +: SQ_W];
               end
               hist_sh_ff <= hist_cur;
               empty_ff   <= (cur_cnt == '0);
               k_ff       <= '0;
               total_ff   <= lite_ff ? K_W'(BASE_WORDS) : K_W'(TOTAL_FULL);
            end
         end
         S_WORD: begin
            std_sum_ff <= snap_sum_ff[ci];
            std_sq_ff  <= snap_sq_ff[ci];
            div_std_ff <= 1'b0;
            rem_ff     <= {1'b0, mean_num[DIV_N_W-1 -: DIV_D_W]};
            nlo_ff     <= mean_num[DIV_Q_W-1:0];
            dvs_ff     <= DIV_D_W'(snap_cnt_ff);
            it_ff      <= 6'(DIV_Q_W - 1);
            if (empty_ff) begin
               val_ff <= '0;
            end else begin
               val_ff <= VALUE_W'({hist_sh_ff[HCNT_W-1:0], 8'b0});
            end
         end
         S_MUL1: begin
            pa_ff <= MUL_W'(snap_cnt_ff) * MUL_W'(std_sq_ff[SQ_LO_W-1:0]);
            pb_ff <= 64'(std_sum_ff) * 64'(std_sum_ff);
            pn_ff <= DIV_D_W'(snap_cnt_ff) * DIV_D_W'(snap_cnt_ff);
         end
         S_MUL2: begin
            ph_ff <= MUL_W'(snap_cnt_ff) * MUL_W'(std_sq_ff[SQ_W-1:SQ_LO_W]);
         end
         S_ADD: begin
            a_ff <= 64'(pa_ff) + (64'(ph_ff) << SQ_LO_W);
         end
         S_SUB: begin
            val_ff     <= '0;
            div_std_ff <= 1'b1;
            rem_ff     <= {1'b0, var_num[DIV_N_W-1 -: DIV_D_W]};
            nlo_ff     <= var_num[DIV_Q_W-1:0];
            dvs_ff     <= pn_ff;
            it_ff      <= 6'(DIV_Q_W - 1);
         end
         S_DIV: begin
            rem_ff <= rem_in;
            nlo_ff <= q_next;
            if (it_ff == 6'd0) begin
               val_ff <= VALUE_W'(q_next);
               sv_ff  <= q_next[SQRT_W-1:0];
               sr_ff  <= '0;
               sb_ff  <= SQRT_W'(1) << (SQRT_W - 2);
               it_ff  <= 6'(SQRT_W / 2 - 1);
            end else begin
               it_ff  <= it_ff - 6'd1;
            end
         end
         S_SQRT: begin
            sv_ff <= sv_in;
            sr_ff <= sr_in;
            sb_ff <= sb_ff >> 2;
            it_ff <= it_ff - 6'd1;
            if (it_ff == 6'd0) val_ff <= VALUE_W'(sr_in);
         end
         S_EMIT: begin
            if (out_free) begin
               k_ff <= k_ff + K_W'(1);
               if (is_hist) hist_sh_ff <= hist_sh_ff >> HCNT_W;
            end
         end
         default: ;
      endcase
   end

   // output register
   logic                rsp_valid_ff, rsp_empty_ff, rsp_last_ff;
   logic [WORD_W-1:0]   rsp_word_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic                emit_fire;

   assign emit_fire = (state_ff == S_EMIT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_word_ff  <= WORD_W'(k_ff);
         rsp_value_ff <= val_ff;
         rsp_empty_ff <= empty_ff;
         rsp_last_ff  <= last_k;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_value_ff, rsp_word_ff};
   assign rsp_tuser  = rsp_empty_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `ASSERT_IMPLY(a_no_write_in_readout, clock, reset, (state_ff != S_IDLE && state_ff != S_CLEAR), !stats_we)
   `ASSERT_IMPLY(a_div_rem_below_divisor, clock, reset, state_ff == S_DIV, rem_ff < {1'b0, dvs_ff})
   `ASSERT_IMPLY(a_variance_fits_root, clock, reset, (state_ff == S_DIV && div_std_ff && it_ff == 6'd0), q_next[DIV_Q_W-1:SQRT_W] == '0)
   `ASSERT_NEXT(a_last_word_ends_run, clock, reset, (emit_fire && last_k), state_ff == S_IDLE)

endmodule

/* sim/tb_top.sv */
// self-checking testbench of the region label statistics unit
// drives pixel and readout requests, predicts every readout word and compares
// depends on rls_pkg and region_label_statistics_unit
module tb_top import rls_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NLAB  = MAX_LABELS_DEF;
   localparam int NBIN  = HIST_BINS_DEF;
   localparam int LIMIT = 200000;

   typedef struct packed {
      logic [WORD_W-1:0]  word_index;
      logic [VALUE_W-1:0] feature_value;
      logic               empty_label;
      logic               last_word;
   } feature_word_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [0:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en;
   logic [0:0]            csr_index;
   logic [CFG_W-1:0]      csr_wdata;

   region_label_statistics_unit dut (.*);

   // shadow copy of the label statistics
   logic [CFG_W-1:0] shadow_label_count;
   logic             shadow_lite;
   logic [23:0] lab_count [NLAB];
   logic [35:0] lab_xsum  [NLAB];
   logic [35:0] lab_ysum  [NLAB];
   logic [31:0] lab_csum  [NLAB][CHAN_N];
   logic [39:0] lab_sqsum [NLAB][CHAN_N];
   logic [23:0] lab_hist  [NLAB][CHAN_N][NBIN];

   feature_word_type expected_words[$];
   int errors = 0;
   int words_seen = 0;
   int readouts = 0;
   int idle_cycles = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] round_mean(logic [63:0] sum, logic [63:0] n);
      if (n == 0) return 0;
      return (sum * 256 + n / 2) / n;
   endfunction

   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] std_dev(logic [63:0] sum, logic [63:0] sq,
                                           logic [63:0] n);
      logic [63:0] a, b, d, nn, q, r, v;
      if (n == 0) return 0;
      a = n * sq;
      b = sum * sum;
      if (a <= b) return 0;
      d = a - b;
      nn = n * n;
      q = d / nn;
      r = d % nn;
      if (q >= (64'd1 << 47)) v = '1;
      else v = (q << 16) + (r << 16) / nn;
      return floor_root(v);
   endfunction

   task automatic push_word(int k, logic [63:0] v, bit empty, int total);
      feature_word_type w;
      w.word_index = k[WORD_W-1:0];
      w.feature_value = v[VALUE_W-1:0];
      w.empty_label = empty;
      w.last_word = (k == total - 1);
      expected_words.insert(expected_words.size(), w);
   endtask

   // update the shadow state and queue the words a request causes
   task automatic predict_request(logic [0:0] op, int lb, int x, int y, int ch[CHAN_N]);
      logic [63:0] n;
      int total, k, j;
      bit empty;
      if (lb >= shadow_label_count) return;
      if (op == OP_PIXEL) begin
         if (lab_count[lb] >= COUNT_MAX) return;
         lab_count[lb]++;
         lab_xsum[lb] += x;
         lab_ysum[lb] += y;
         for (int c = 0; c < CHAN_N; c++) begin
            lab_csum[lb][c] += ch[c];
            lab_sqsum[lb][c] += ch[c] * ch[c];
            if (!shadow_lite) lab_hist[lb][c][(ch[c] * NBIN) >> 8]++;
         end
         return;
      end
      readouts++;
      n = lab_count[lb];
      empty = (n == 0);
      total = shadow_lite ? BASE_WORDS : BASE_WORDS + CHAN_N * NBIN;
      push_word(0, round_mean(lab_xsum[lb], n), empty, total);
      push_word(1, round_mean(lab_ysum[lb], n), empty, total);
      for (int c = 0; c < 3; c++) begin
         k = 2 + 4 * c;
         j = c + 3;
         push_word(k, round_mean(lab_csum[lb][c], n), empty, total);
         push_word(k + 1, std_dev(lab_csum[lb][c], lab_sqsum[lb][c], n), empty, total);
         push_word(k + 2, round_mean(lab_csum[lb][j], n), empty, total);
         push_word(k + 3, std_dev(lab_csum[lb][j], lab_sqsum[lb][j], n), empty, total);
      end
      if (!shadow_lite) begin
         k = BASE_WORDS;
         for (int c = 0; c < CHAN_N; c++)
            for (int h = 0; h < NBIN; h++) begin
               push_word(k, empty ? 64'd0 : 64'(lab_hist[lb][c][h]) * 256, empty, total);
               k++;
            end
      end
      lab_count[lb] = 0;
      lab_xsum[lb] = 0;
      lab_ysum[lb] = 0;
      for (int c = 0; c < CHAN_N; c++) begin
         lab_csum[lb][c] = 0;
         lab_sqsum[lb][c] = 0;
         for (int h = 0; h < NBIN; h++) lab_hist[lb][c][h] = 0;
      end
   endtask

   // send one request with a random gap ahead of it unless no_gap is set; valid drops only during a gap
   task automatic send_request(logic [0:0] op, int lb, int x, int y, int ch[CHAN_N],
                               bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'd0, ch[5][7:0], ch[4][7:0], ch[3][7:0], ch[2][7:0], ch[1][7:0],
                     ch[0][7:0], y[11:0], x[11:0], lb[9:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(op, lb, x, y, ch);
   endtask

   task automatic send_pixel(int lb, bit no_gap = 0);
      int ch[CHAN_N];
      foreach (ch[c]) ch[c] = $urandom_range(0, 255);
      send_request(OP_PIXEL, lb, $urandom_range(0, 4095), $urandom_range(0, 4095), ch, no_gap);
   endtask

   task automatic send_readout(int lb);
      int ch[CHAN_N];
      foreach (ch[c]) ch[c] = $urandom_range(0, 255);
      send_request(OP_READOUT, lb, $urandom_range(0, 4095), $urandom_range(0, 4095), ch);
   endtask

   // wait until every readout word has come, plus a short margin
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_register(logic [0:0] idx, int value);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CFG_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_LABEL_COUNT) shadow_label_count = value[CFG_W-1:0];
      else shadow_lite = value[0];
   endtask

   // extremes of every field and an empty label
   task automatic test_directed();
      int lo[CHAN_N], hi[CHAN_N];
      foreach (lo[c]) begin
         lo[c] = 0;
         hi[c] = 255;
      end
      send_readout(0);
      send_request(OP_PIXEL, 0, 0, 0, lo);
      send_request(OP_PIXEL, 0, 4095, 4095, hi);
      send_request(OP_PIXEL, 0, 2048, 1, hi);
      send_readout(0);
      send_request(OP_PIXEL, 1023, 4095, 0, hi);
      send_request(OP_PIXEL, 1023, 1, 4095, lo);
      send_readout(1023);
      send_request(OP_PIXEL, 5, 7, 9, hi);
      send_readout(5);
      send_readout(5);
   endtask

   // narrow label range and lite mode, switched mid-stream
   task automatic test_config();
      write_register(REG_LABEL_COUNT, 1);
      send_pixel(0);
      send_pixel(1);
      send_pixel(1023);
      send_readout(1);
      send_readout(0);
      write_register(REG_LITE_MODE, 1);
      send_pixel(0);
      send_pixel(0);
      send_readout(0);
      send_pixel(0);
      write_register(REG_LITE_MODE, 0);
      send_pixel(0);
      send_readout(0);
      write_register(REG_LABEL_COUNT, 2047);
      send_pixel(1023);
      send_readout(1023);
   endtask

   // bursts of pixels into a few labels with occasional readouts, then a readout of every label
   task automatic test_random(int items, int nlab);
      int lb;
      for (int i = 0; i < items; i++) begin
         lb = $urandom_range(0, nlab - 1);
         if ($urandom_range(0, 11) == 0) begin
            send_readout(lb);
            if ($urandom_range(0, 5) == 0) drain();
         end else begin
            send_pixel($urandom_range(0, 19) == 0 ? $urandom_range(0, 1023) : lb,
                       $urandom_range(0, 2) == 0);
         end
      end
      for (int l = 0; l < nlab; l++) send_readout(l);
   endtask

   // check each accepted readout word against the oldest expectation
   always @(posedge clock) begin
      feature_word_type exp_w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (expected_words.size() == 0) begin
            $error("unexpected readout word, index %0d", rsp_tdata[5:0]);
            errors++;
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_tdata[5:0] !== exp_w.word_index) begin
               $error("word_index exp %0d got %0d", exp_w.word_index, rsp_tdata[5:0]);
               errors++;
            end
            if (rsp_tdata[45:6] !== exp_w.feature_value) begin
               $error("feature_value (word %0d) exp %0d got %0d", exp_w.word_index,
                      exp_w.feature_value, rsp_tdata[45:6]);
               errors++;
            end
            if (rsp_tuser !== exp_w.empty_label) begin
               $error("empty_label exp %0b got %0b", exp_w.empty_label, rsp_tuser);
               errors++;
            end
            if (rsp_tlast !== exp_w.last_word) begin
               $error("last_word exp %0b got %0b", exp_w.last_word, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // receiver stalls: a random hold-off before each word, with stall-free stretches
   initial begin
      int wait_n;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (wait_n != 0) rsp_tready <= 1'b0;
         end else if (!rsp_tready) begin
            if (wait_n == 0) rsp_tready <= 1'b1;
            else wait_n--;
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_PIXEL;
      csr_wr_en  <= 1'b0;
      csr_index  <= REG_LABEL_COUNT;
      csr_wdata  <= '0;
      shadow_label_count = LABEL_COUNT_RST;
      shadow_lite = 1'b0;
      for (int l = 0; l < NLAB; l++) begin
         lab_count[l] = 0;
         lab_xsum[l] = 0;
         lab_ysum[l] = 0;
         for (int c = 0; c < CHAN_N; c++) begin
            lab_csum[l][c] = 0;
            lab_sqsum[l][c] = 0;
            for (int h = 0; h < NBIN; h++) lab_hist[l][c][h] = 0;
         end
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config();
      write_register(REG_LABEL_COUNT, 8);
      test_random(100, 8);
      write_register(REG_LITE_MODE, 1);
      test_random(50, 4);
      write_register(REG_LITE_MODE, 0);
      write_register(REG_LABEL_COUNT, 1024);
      test_random(60, 6);
      drain();
      $display("covered %0d readouts and %0d feature words, lite and full mode,", readouts,
               words_seen);
      $display("label limits from 1 to 2047 and out of range labels");
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

/* region_label_statistics_unit.f */
+incdir+design
design/rls_pkg.sv
design/rls_ram.sv
design/region_label_statistics_unit.sv
sim/tb_top.sv
